### hw/rtl/fotb_pkg.sv
// ----------------------------------------------------------------------------
// fotb_pkg: framed object transmit buffer package
// Action codes, field widths and the result word type.
// ----------------------------------------------------------------------------
`default_nettype none

package fotb_pkg;

  localparam int unsigned ACT_W  = 3;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned OUT_W  = 6;

  localparam logic [BYTE_W-1:0] NO_BYTE = 8'hff;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUT    = 3'd0,
    ACT_END    = 3'd1,
    ACT_FETCH  = 3'd2,
    ACT_REMOVE = 3'd3,
    ACT_REWIND = 3'd4
  } act_e;

  typedef struct packed {
    logic              ok;
    logic [BYTE_W-1:0] tx_byte;
    logic [OUT_W-1:0]  current_size;
    logic [OUT_W-1:0]  remaining_size;
    logic [OUT_W-1:0]  object_count;
  } res_t;

endpackage

`default_nettype wire

### hw/rtl/fotb_ram.sv
// ----------------------------------------------------------------------------
// fotb_ram: ring storage
// One write port, one registered read port; a write to the address being
// read in the same cycle is forwarded to the read register.
// ----------------------------------------------------------------------------
`default_nettype none

module fotb_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/fotb_engine.sv
// ----------------------------------------------------------------------------
// fotb_engine: ring pointers and action logic
// Applies one action per fire, drives the ring write and read-ahead ports
// and forms the result word from the updated pointers.
// ----------------------------------------------------------------------------
`default_nettype none

module fotb_engine #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            fire_i,
  input  wire logic [fotb_pkg::ACT_W-1:0]      action_i,
  input  wire logic [fotb_pkg::BYTE_W-1:0]     data_byte_i,
  // byte ring
  output logic                                 byte_we_o,
  output logic      [$clog2(DEPTH)-1:0]        byte_waddr_o,
  output logic      [fotb_pkg::BYTE_W-1:0]     byte_wdata_o,
  output logic      [$clog2(DEPTH)-1:0]        byte_raddr_o,
  input  wire logic [fotb_pkg::BYTE_W-1:0]     byte_rdata_i,
  // mark ring
  output logic                                 mark_we_o,
  output logic      [$clog2(DEPTH)-1:0]        mark_waddr_o,
  output logic      [$clog2(DEPTH)-1:0]        mark_wdata_o,
  output logic      [$clog2(DEPTH)-1:0]        mark_raddr_o,
  input  wire logic [$clog2(DEPTH)-1:0]        mark_rdata_i,
  output fotb_pkg::res_t                       res_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned OW = fotb_pkg::OUT_W;

  function automatic logic [PW-1:0] inc_w(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] dec_w(input logic [PW-1:0] p);
    return (p == '0) ? PW'(DEPTH - 1) : p - PW'(1);
  endfunction

  function automatic logic [PW-1:0] sub_w(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic [PW:0] r;
    if (a >= b) begin
      r = {1'b0, a} - {1'b0, b};
    end else begin
      r = {1'b0, a} + (PW+1)'(DEPTH) - {1'b0, b};
    end
    return r[PW-1:0];
  endfunction

  logic [PW-1:0] read_pos_q,   read_pos_d;
  logic [PW-1:0] write_mark_q, write_mark_d;
  logic [PW-1:0] head_q,       head_d;
  logic [PW-1:0] tail_q,       tail_d;
  logic [PW-1:0] offset_q,     offset_d;
  logic [PW-1:0] fetch_pos_q,  fetch_pos_d;
  logic [PW-1:0] head_mark_q,  head_mark_d;

  logic          have_obj_pre, have_obj_post;
  logic [PW-1:0] size_pre, size_post, rem_post, count_post;
  logic          ok, fetch_ok;

  always_comb begin
    read_pos_d   = read_pos_q;
    write_mark_d = write_mark_q;
    head_d       = head_q;
    tail_d       = tail_q;
    offset_d     = offset_q;
    fetch_pos_d  = fetch_pos_q;
    head_mark_d  = head_mark_q;
    ok           = 1'b0;
    fetch_ok     = 1'b0;
    byte_we_o    = 1'b0;
    mark_we_o    = 1'b0;
    byte_waddr_o = dec_w(write_mark_q);
    byte_wdata_o = data_byte_i;
    mark_waddr_o = dec_w(tail_q);
    mark_wdata_o = dec_w(write_mark_q);

    have_obj_pre = (inc_w(head_q) != tail_q);
    size_pre     = have_obj_pre ? sub_w(head_mark_q, read_pos_q) : '0;

    if (fire_i) begin
      case (action_i)
        fotb_pkg::ACT_PUT: begin
          if (write_mark_q != read_pos_q) begin
            byte_we_o    = 1'b1;
            write_mark_d = inc_w(write_mark_q);
            ok           = 1'b1;
          end
        end
        fotb_pkg::ACT_END: begin
          if (tail_q != head_q) begin
            mark_we_o = 1'b1;
            tail_d    = inc_w(tail_q);
            ok        = 1'b1;
            // first queued mark lands in the head slot
            if (!have_obj_pre) begin
              head_mark_d = dec_w(write_mark_q);
            end
          end
        end
        fotb_pkg::ACT_FETCH: begin
          if ((inc_w(read_pos_q) != write_mark_q) && (offset_q < size_pre)) begin
            offset_d    = offset_q + PW'(1);
            fetch_pos_d = inc_w(fetch_pos_q);
            fetch_ok    = 1'b1;
            ok          = 1'b1;
          end
        end
        fotb_pkg::ACT_REMOVE: begin
          if (have_obj_pre) begin
            read_pos_d  = head_mark_q;
            head_d      = inc_w(head_q);
            head_mark_d = mark_rdata_i;
            offset_d    = '0;
            fetch_pos_d = head_mark_q;
            ok          = 1'b1;
          end
        end
        fotb_pkg::ACT_REWIND: begin
          offset_d    = '0;
          fetch_pos_d = read_pos_q;
          ok          = 1'b1;
        end
        default: begin
        end
      endcase
    end

    byte_raddr_o = fetch_pos_d;
    mark_raddr_o = inc_w(head_d);

    have_obj_post = (inc_w(head_d) != tail_d);
    size_post     = have_obj_post ? sub_w(head_mark_d, read_pos_d) : '0;
    rem_post      = (offset_d < size_post) ? (size_post - offset_d) : '0;
    count_post    = sub_w(dec_w(tail_d), head_d);

    res_o.ok             = ok;
    res_o.tx_byte        = fetch_ok ? byte_rdata_i : fotb_pkg::NO_BYTE;
    res_o.current_size   = OW'(size_post);
    res_o.remaining_size = OW'(rem_post);
    res_o.object_count   = OW'(count_post);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_pos_q   <= '0;
      write_mark_q <= PW'(1);
      head_q       <= '0;
      tail_q       <= PW'(1);
      offset_q     <= '0;
      fetch_pos_q  <= '0;
      head_mark_q  <= '0;
    end else begin
      read_pos_q   <= read_pos_d;
      write_mark_q <= write_mark_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      offset_q     <= offset_d;
      fetch_pos_q  <= fetch_pos_d;
      head_mark_q  <= head_mark_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/framed_object_tx_buffer_core.sv
// ----------------------------------------------------------------------------
// framed_object_tx_buffer_core: framed object transmit buffer
// An accepted word waits in the input register until it advances.
// Throughput: one word per cycle while the output is not stalled; each action
// is one pass from the input register through the pointer logic into the
// result register. Reset: pointers return to their empty-ring values at once;
// ring contents are not cleared and need no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module framed_object_tx_buffer_core #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [fotb_pkg::ACT_W-1:0]   action_i,
  input  wire logic [fotb_pkg::BYTE_W-1:0]  data_byte_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              ok_o,
  output logic      [fotb_pkg::BYTE_W-1:0]  tx_byte_o,
  output logic      [fotb_pkg::OUT_W-1:0]   current_size_o,
  output logic      [fotb_pkg::OUT_W-1:0]   remaining_size_o,
  output logic      [fotb_pkg::OUT_W-1:0]   object_count_o
);

  localparam int unsigned PW = $clog2(DEPTH);

  logic                          in_valid_q, in_valid_d;
  logic [fotb_pkg::ACT_W-1:0]    action_q;
  logic [fotb_pkg::BYTE_W-1:0]   data_q;
  logic                          out_valid_q, out_valid_d;
  fotb_pkg::res_t                res_q, res_d;
  logic                          accept, adv;

  logic                          byte_we, mark_we;
  logic [PW-1:0]                 byte_waddr, byte_raddr, mark_waddr, mark_raddr;
  logic [PW-1:0]                 mark_wdata, mark_rdata;
  logic [fotb_pkg::BYTE_W-1:0]   byte_wdata, byte_rdata;

  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d  = accept ? 1'b1 : (adv ? 1'b0 : in_valid_q);
    out_valid_d = adv ? 1'b1 : (out_valid_q && !out_stall_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= action_i;
      data_q   <= data_byte_i;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  fotb_engine #(.DEPTH(DEPTH)) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (adv),
    .action_i     (action_q),
    .data_byte_i  (data_q),
    .byte_we_o    (byte_we),
    .byte_waddr_o (byte_waddr),
    .byte_wdata_o (byte_wdata),
    .byte_raddr_o (byte_raddr),
    .byte_rdata_i (byte_rdata),
    .mark_we_o    (mark_we),
    .mark_waddr_o (mark_waddr),
    .mark_wdata_o (mark_wdata),
    .mark_raddr_o (mark_raddr),
    .mark_rdata_i (mark_rdata),
    .res_o        (res_d)
  );

  fotb_ram #(.DEPTH(DEPTH), .WIDTH(fotb_pkg::BYTE_W)) u_byte_ring (
    .clk_i   (clk_i),
    .we_i    (byte_we),
    .waddr_i (byte_waddr),
    .wdata_i (byte_wdata),
    .raddr_i (byte_raddr),
    .rdata_o (byte_rdata)
  );

  fotb_ram #(.DEPTH(DEPTH), .WIDTH(PW)) u_mark_ring (
    .clk_i   (clk_i),
    .we_i    (mark_we),
    .waddr_i (mark_waddr),
    .wdata_i (mark_wdata),
    .raddr_i (mark_raddr),
    .rdata_o (mark_rdata)
  );

  assign out_valid_o      = out_valid_q;
  assign ok_o             = res_q.ok;
  assign tx_byte_o        = res_q.tx_byte;
  assign current_size_o   = res_q.current_size;
  assign remaining_size_o = res_q.remaining_size;
  assign object_count_o   = res_q.object_count;

  // a failed or non-fetch action never returns a data byte
  a_no_byte_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> (tx_byte_o == fotb_pkg::NO_BYTE))
    else $error("tx byte set on failed action");

  // input side stalls only behind a held result word
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  // a new result word only comes from a held input word
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_q))
    else $error("result word without input word");

endmodule

`default_nettype wire
